@@ rtl/crse_pkg.sv @@
// Shared constants, types and helpers for the capacity route split evaluator.
// No dependencies; the top level references everything here by scoped name.
package crse_pkg;

   localparam int COORD_W   = 16;
   localparam int DEMAND_W  = 16;
   localparam int CAP_W     = 16;
   localparam int LOAD_W    = 18;
   localparam int VISIT_W   = 11;
   localparam int DIST_W    = 40;
   localparam int DELTA_W   = COORD_W + 1;
   localparam int SQ_W      = 2 * COORD_W + 1;
   localparam int FRAC_W    = 16;
   localparam int OP_W      = ((SQ_W + FRAC_W + 1) / 2) * 2;
   localparam int ROOT_W    = OP_W / 2;
   localparam int REM_W     = ROOT_W + 1;
   localparam int SQ_STEPS  = COORD_W;
   localparam int ROOT_STEPS = ROOT_W;
   localparam int CNT_W     = 5;

   typedef logic [1:0] leg_code_type;

   localparam leg_code_type LEG_PREV_ORIGIN = 2'd0;
   localparam leg_code_type LEG_ORIGIN_NODE = 2'd1;
   localparam leg_code_type LEG_PREV_NODE   = 2'd2;
   localparam leg_code_type LEG_NODE_ORIGIN = 2'd3;

   localparam logic [VISIT_W-1:0] VISIT_MAX = '1;

   function automatic logic [VISIT_W-1:0] visit_inc(input logic [VISIT_W-1:0] v);
      return (v == VISIT_MAX) ? v : v + 1'b1;
   endfunction

   function automatic logic [DIST_W-1:0] dist_add(input logic [DIST_W-1:0] acc,
                                                  input logic [ROOT_W-1:0] leg);
      logic [DIST_W:0] sum;
      sum = {1'b0, acc} + {{(DIST_W + 1 - ROOT_W){1'b0}}, leg};
      return sum[DIST_W] ? {DIST_W{1'b1}} : sum[DIST_W-1:0];
   endfunction

endpackage

@@ rtl/capacity_route_split_evaluator_unit.sv @@
// Top level of the capacity route split evaluator: tour state, leg sequencer,
// bit-serial squaring unit and radix-2 restoring square root.
// Depends on crse_pkg.
//
// Nodes of a tour are taken one at a time; the block is ready again only
// when the previous node is fully evaluated. Each leg takes a setup step,
// the shift-add squarer (one multiplier bit per cycle) and the square root
// (two operand bits per cycle). A node takes one leg when direct, two when
// the vehicle refills or the node is the last, and three when both; on the
// last node the result is then handed to the output register, which waits
// while an earlier result is still unaccepted.
// The result register lets the next tour start while the result waits.
module capacity_route_split_evaluator_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [crse_pkg::CAP_W-1:0]            csr_vehicle_capacity,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [crse_pkg::COORD_W-1:0]   req_node_x,
   input  logic signed [crse_pkg::COORD_W-1:0]   req_node_y,
   input  logic [crse_pkg::DEMAND_W-1:0]         req_node_demand,
   input  logic                                  req_last_node,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [crse_pkg::VISIT_W-1:0]          rsp_depot_visits,
   output logic [crse_pkg::DIST_W-1:0]           rsp_route_distance
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SETUP  = 3'd1;
   localparam logic [2:0] ST_SQUARE = 3'd2;
   localparam logic [2:0] ST_ROOT   = 3'd3;
   localparam logic [2:0] ST_EMIT   = 3'd4;

   localparam int CW = crse_pkg::COORD_W;
   localparam int SW = crse_pkg::SQ_W;

   logic [2:0]                        state_ff, state_in;
   logic                              tour_start_ff, tour_start_in;
   logic [crse_pkg::CAP_W-1:0]        capacity_ff, capacity_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [crse_pkg::CNT_W-1:0]        cnt_ff, cnt_in;
   crse_pkg::leg_code_type            leg_ff, leg_in;

   logic signed [crse_pkg::LOAD_W-1:0] load_ff, load_in;
   logic signed [CW-1:0]              prev_x_ff, prev_x_in;
   logic signed [CW-1:0]              prev_y_ff, prev_y_in;
   logic signed [CW-1:0]              node_x_ff, node_x_in;
   logic signed [CW-1:0]              node_y_ff, node_y_in;
   logic                              last_ff, last_in;
   logic [crse_pkg::VISIT_W-1:0]      visit_ff, visit_in;
   logic [crse_pkg::DIST_W-1:0]       dist_ff, dist_in;

   logic [CW-1:0]                     ax_mul_ff, ax_mul_in;
   logic [CW-1:0]                     ay_mul_ff, ay_mul_in;
   logic [2*CW-1:0]                   ax_sh_ff, ax_sh_in;
   logic [2*CW-1:0]                   ay_sh_ff, ay_sh_in;
   logic [SW-1:0]                     sq_ff, sq_in;

   logic [crse_pkg::OP_W-1:0]         op_ff, op_in;
   logic [crse_pkg::REM_W-1:0]        rem_ff, rem_in;
   logic [crse_pkg::ROOT_W-1:0]       root_ff, root_in;

   logic [crse_pkg::VISIT_W-1:0]      rsp_visits_ff, rsp_visits_in;
   logic [crse_pkg::DIST_W-1:0]       rsp_dist_ff, rsp_dist_in;

   logic                              req_xfer;
   logic signed [crse_pkg::LOAD_W-1:0] load_start;
   logic signed [crse_pkg::LOAD_W-1:0] load_diff;
   logic signed [crse_pkg::LOAD_W-1:0] load_refill;
   logic [crse_pkg::VISIT_W-1:0]      visit_start;
   logic                              refill;

   logic [CW-1:0]                     src_x, src_y, sub_x, sub_y;
   logic [crse_pkg::DELTA_W-1:0]      dx, dy, dx_neg, dy_neg;

   logic [crse_pkg::REM_W+1:0]        rem_sh;
   logic [crse_pkg::REM_W+1:0]        trial;
   logic                              root_ge;
   logic [crse_pkg::ROOT_W-1:0]       root_next;

   logic                              more_legs;
   crse_pkg::leg_code_type            next_leg;

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign req_xfer  = req_valid & req_ready;

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_depot_visits   = rsp_visits_ff;
   assign rsp_route_distance = rsp_dist_ff;

   // Load bookkeeping at node entry
   always_comb begin
      load_start  = tour_start_ff ? $signed({2'b00, capacity_ff}) : load_ff;
      load_diff   = load_start - $signed({2'b00, req_node_demand});
      load_refill = $signed({2'b00, capacity_ff}) - $signed({2'b00, req_node_demand});
      refill      = load_diff[crse_pkg::LOAD_W-1];
      visit_start = tour_start_ff ? '0 : visit_ff;
   end

   // Leg endpoints
   always_comb begin
      if (leg_ff == crse_pkg::LEG_PREV_ORIGIN || leg_ff == crse_pkg::LEG_PREV_NODE) begin
         src_x = prev_x_ff;
         src_y = prev_y_ff;
      end else begin
         src_x = '0;
         src_y = '0;
      end
      if (leg_ff == crse_pkg::LEG_PREV_ORIGIN) begin
         sub_x = '0;
         sub_y = '0;
      end else begin
         sub_x = node_x_ff;
         sub_y = node_y_ff;
      end
      dx     = {src_x[CW-1], src_x} - {sub_x[CW-1], sub_x};
      dy     = {src_y[CW-1], src_y} - {sub_y[CW-1], sub_y};
      dx_neg = '0 - dx;
      dy_neg = '0 - dy;
   end

   // One root digit per cycle
   always_comb begin
      rem_sh    = {rem_ff, op_ff[crse_pkg::OP_W-1 -: 2]};
      trial     = {1'b0, root_ff, 2'b01};
      root_ge   = (rem_sh >= trial);
      root_next = {root_ff[crse_pkg::ROOT_W-2:0], root_ge};
   end

   always_comb begin
      more_legs = 1'b0;
      next_leg  = crse_pkg::LEG_NODE_ORIGIN;
      case (leg_ff) inside
         crse_pkg::LEG_PREV_ORIGIN: begin
            more_legs = 1'b1;
            next_leg  = crse_pkg::LEG_ORIGIN_NODE;
         end
         crse_pkg::LEG_ORIGIN_NODE, crse_pkg::LEG_PREV_NODE: begin
            more_legs = last_ff;
            next_leg  = crse_pkg::LEG_NODE_ORIGIN;
         end
         default: begin
            more_legs = 1'b0;
            next_leg  = crse_pkg::LEG_NODE_ORIGIN;
         end
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      tour_start_in = tour_start_ff;
      capacity_in   = (csr_valid & csr_ready) ? csr_vehicle_capacity : capacity_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_ready;
      cnt_in        = cnt_ff;
      leg_in        = leg_ff;
      load_in       = load_ff;
      prev_x_in     = prev_x_ff;
      prev_y_in     = prev_y_ff;
      node_x_in     = node_x_ff;
      node_y_in     = node_y_ff;
      last_in       = last_ff;
      visit_in      = visit_ff;
      dist_in       = dist_ff;
      ax_mul_in     = ax_mul_ff;
      ay_mul_in     = ay_mul_ff;
      ax_sh_in      = ax_sh_ff;
      ay_sh_in      = ay_sh_ff;
      sq_in         = sq_ff;
      op_in         = op_ff;
      rem_in        = rem_ff;
      root_in       = root_ff;
      rsp_visits_in = rsp_visits_ff;
      rsp_dist_in   = rsp_dist_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               tour_start_in = 1'b0;
               node_x_in     = req_node_x;
               node_y_in     = req_node_y;
               last_in       = req_last_node;
               prev_x_in     = tour_start_ff ? '0 : prev_x_ff;
               prev_y_in     = tour_start_ff ? '0 : prev_y_ff;
               dist_in       = tour_start_ff ? '0 : dist_ff;
               load_in       = refill ? load_refill : load_diff;
               visit_in      = refill ? crse_pkg::visit_inc(visit_start) : visit_start;
               leg_in        = refill ? crse_pkg::LEG_PREV_ORIGIN : crse_pkg::LEG_PREV_NODE;
               state_in      = ST_SETUP;
            end
         end
         ST_SETUP: begin
            ax_mul_in = dx[crse_pkg::DELTA_W-1] ? dx_neg[CW-1:0] : dx[CW-1:0];
            ay_mul_in = dy[crse_pkg::DELTA_W-1] ? dy_neg[CW-1:0] : dy[CW-1:0];
            ax_sh_in  = {{CW{1'b0}}, ax_mul_in};
            ay_sh_in  = {{CW{1'b0}}, ay_mul_in};
            sq_in     = '0;
            cnt_in    = crse_pkg::CNT_W'(crse_pkg::SQ_STEPS - 1);
            state_in  = ST_SQUARE;
         end
         ST_SQUARE: begin
            sq_in = sq_ff
                  + (ax_mul_ff[0] ? {1'b0, ax_sh_ff} : '0)
                  + (ay_mul_ff[0] ? {1'b0, ay_sh_ff} : '0);
            ax_mul_in = ax_mul_ff >> 1;
            ay_mul_in = ay_mul_ff >> 1;
            ax_sh_in  = ax_sh_ff << 1;
            ay_sh_in  = ay_sh_ff << 1;
            if (cnt_ff == '0) begin
               op_in    = {{(crse_pkg::OP_W - SW - crse_pkg::FRAC_W){1'b0}}, sq_in,
                           {crse_pkg::FRAC_W{1'b0}}};
               rem_in   = '0;
               root_in  = '0;
               cnt_in   = crse_pkg::CNT_W'(crse_pkg::ROOT_STEPS - 1);
               state_in = ST_ROOT;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         ST_ROOT: begin
            rem_in  = root_ge ? crse_pkg::REM_W'(rem_sh - trial) : rem_sh[crse_pkg::REM_W-1:0];
            root_in = root_next;
            op_in   = op_ff << 2;
            cnt_in  = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               dist_in = crse_pkg::dist_add(dist_ff, root_next);
               if (more_legs) begin
                  leg_in   = next_leg;
                  state_in = ST_SETUP;
               end else begin
                  prev_x_in = node_x_ff;
                  prev_y_in = node_y_ff;
                  state_in  = last_ff ? ST_EMIT : ST_IDLE;
               end
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_visits_in = crse_pkg::visit_inc(visit_ff);
               rsp_dist_in   = dist_ff;
               tour_start_in = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         tour_start_ff <= 1'b1;
         capacity_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
         cnt_ff        <= '0;
         leg_ff        <= crse_pkg::LEG_PREV_NODE;
      end else begin
         state_ff      <= state_in;
         tour_start_ff <= tour_start_in;
         capacity_ff   <= capacity_in;
         rsp_valid_ff  <= rsp_valid_in;
         cnt_ff        <= cnt_in;
         leg_ff        <= leg_in;
      end
   end

   always_ff @(posedge clock) begin
      load_ff       <= load_in;
      prev_x_ff     <= prev_x_in;
      prev_y_ff     <= prev_y_in;
      node_x_ff     <= node_x_in;
      node_y_ff     <= node_y_in;
      last_ff       <= last_in;
      visit_ff      <= visit_in;
      dist_ff       <= dist_in;
      ax_mul_ff     <= ax_mul_in;
      ay_mul_ff     <= ay_mul_in;
      ax_sh_ff      <= ax_sh_in;
      ay_sh_ff      <= ay_sh_in;
      sq_ff         <= sq_in;
      op_ff         <= op_in;
      rem_ff        <= rem_in;
      root_ff       <= root_in;
      rsp_visits_ff <= rsp_visits_in;
      rsp_dist_ff   <= rsp_dist_in;
   end

`ifndef SYNTHESIS
   a_root_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ROOT |-> cnt_ff < crse_pkg::CNT_W'(crse_pkg::ROOT_STEPS))
      else $error("root digit counter out of range");

   a_square_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SQUARE |-> cnt_ff < crse_pkg::CNT_W'(crse_pkg::SQ_STEPS))
      else $error("square bit counter out of range");

   a_result_closes_tour: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> tour_start_ff && state_ff == ST_IDLE)
      else $error("result issued without closing the tour");

   a_visits_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_visits_ff != '0)
      else $error("result without final depot visit");
`endif

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for capacity_route_split_evaluator_unit: tours of customer nodes
// go in through a queue-fed driver, route totals are predicted and checked by a monitor.
// Depends on crse_pkg and the top level RTL only.
module tb_top;

   localparam int GAP_MAX        = 17;
   localparam int LONG_HOLD      = 600;
   localparam int DRAIN_CYCLES   = 256;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int OVERLONG_NODES = 40;
   localparam logic [crse_pkg::DIST_W-1:0]  DIST_CEIL  = '1;
   localparam logic [crse_pkg::VISIT_W-1:0] VISIT_CEIL = '1;

   typedef struct {
      logic signed [crse_pkg::COORD_W-1:0] x;
      logic signed [crse_pkg::COORD_W-1:0] y;
      logic [crse_pkg::DEMAND_W-1:0]       demand;
      logic                                last;
   } node_type;

   typedef struct {
      logic [crse_pkg::VISIT_W-1:0] visits;
      logic [crse_pkg::DIST_W-1:0]  distance;
   } route_total_type;

   logic clock;
   logic reset = 1'b1;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [crse_pkg::CAP_W-1:0] csr_vehicle_capacity = '0;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [crse_pkg::COORD_W-1:0] req_node_x = '0;
   logic signed [crse_pkg::COORD_W-1:0] req_node_y = '0;
   logic [crse_pkg::DEMAND_W-1:0] req_node_demand = '0;
   logic req_last_node = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [crse_pkg::VISIT_W-1:0] rsp_depot_visits;
   logic [crse_pkg::DIST_W-1:0] rsp_route_distance;

   capacity_route_split_evaluator_unit u_top (
      .clock                (clock),
      .reset                (reset),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_vehicle_capacity (csr_vehicle_capacity),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_node_x           (req_node_x),
      .req_node_y           (req_node_y),
      .req_node_demand      (req_node_demand),
      .req_last_node        (req_last_node),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_depot_visits     (rsp_depot_visits),
      .rsp_route_distance   (rsp_route_distance)
   );

   // tour state mirrored from the block
   logic [crse_pkg::CAP_W-1:0]   fleet_capacity = '0;
   int                           load_left      = 0;
   int                           last_x         = 0;
   int                           last_y         = 0;
   logic [crse_pkg::VISIT_W-1:0] visit_tally    = '0;
   logic [crse_pkg::DIST_W-1:0]  distance_tally = '0;
   bit                           tour_open      = 1'b0;

   node_type        node_q[$];
   route_total_type route_totals_q[$];
   node_type        node_on_bus;
   int           items_outstanding = 0;
   int           error_count       = 0;
   bit           quiet_mode        = 1'b0;
   int           long_holds_asked  = 0;
   int           long_holds_done   = 0;
   int           send_gap          = 0;
   int           stall_left        = 0;
   bit           long_hold_on      = 1'b0;
   bit           offer;
   int           idle_cycles       = 0;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic int draw_gap();
      return quiet_mode ? 0 : $urandom_range(0, GAP_MAX);
   endfunction

   function automatic longint unsigned floor_root(input longint unsigned v);
      longint unsigned rest, root, probe;
      rest  = v;
      root  = 0;
      probe = 64'h4000_0000_0000_0000;
      while (probe > v)
         probe >>= 2;
      while (probe != 0) begin
         if (rest >= root + probe) begin
            rest -= root + probe;
            root  = (root >> 1) + probe;
         end else begin
            root >>= 1;
         end
         probe >>= 2;
      end
      return root;
   endfunction

   function automatic longint unsigned leg_length(input int ax, input int ay,
                                                  input int bx, input int by);
      longint unsigned dx, dy;
      dx = (ax >= bx) ? longint'(ax - bx) : longint'(bx - ax);
      dy = (ay >= by) ? longint'(ay - by) : longint'(by - ay);
      return floor_root((dx * dx + dy * dy) << 16);
   endfunction

   task automatic add_leg(input longint unsigned len);
      longint unsigned sum;
      sum = longint'(distance_tally) + len;
      distance_tally = (sum > longint'(DIST_CEIL)) ? DIST_CEIL : sum[crse_pkg::DIST_W-1:0];
   endtask

   task automatic add_visit();
      if (visit_tally != VISIT_CEIL)
         visit_tally++;
   endtask

   task automatic evaluate_node(input node_type n);
      int x, y, need;
      route_total_type total;
      x    = n.x;
      y    = n.y;
      need = n.demand;
      if (!tour_open) begin
         load_left      = fleet_capacity;
         last_x         = 0;
         last_y         = 0;
         visit_tally    = '0;
         distance_tally = '0;
         tour_open      = 1'b1;
      end
      if (load_left - need < 0) begin
         add_visit();
         add_leg(leg_length(last_x, last_y, 0, 0));
         add_leg(leg_length(0, 0, x, y));
         load_left = fleet_capacity;
      end else begin
         add_leg(leg_length(last_x, last_y, x, y));
      end
      load_left -= need;
      last_x = x;
      last_y = y;
      if (n.last) begin
         add_leg(leg_length(x, y, 0, 0));
         add_visit();
         total.visits   = visit_tally;
         total.distance = distance_tally;
         route_totals_q = {route_totals_q, total};
         tour_open = 1'b0;
      end
   endtask

   task automatic report_mismatch(input string msg);
      $display("MISMATCH at %0t ns: %s", $time, msg);
      error_count++;
   endtask

   task automatic push_node(input int x, input int y, input int demand, input bit last);
      node_type n;
      n.x      = 16'(x);
      n.y      = 16'(y);
      n.demand = 16'(demand);
      n.last   = last;
      node_q = {node_q, n};
      items_outstanding++;
   endtask

   task automatic write_capacity(input logic [crse_pkg::CAP_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_vehicle_capacity <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      fleet_capacity = value;
   endtask

   task automatic wait_idle();
      while (items_outstanding != 0 || route_totals_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic queue_random_tours(input int count, input bit close_tour);
      int tour_left, coord_x, coord_y, demand;
      bit last;
      tour_left = 0;
      for (int i = 0; i < count; i++) begin
         if (tour_left == 0)
            tour_left = ($urandom_range(0, 7) == 0) ? 30 : $urandom_range(1, 12);
         tour_left--;
         last = (tour_left == 0) || (close_tour && i == count - 1);
         if (last)
            tour_left = 0;
         if ($urandom_range(0, 3) == 0) begin
            coord_x = int'($urandom_range(0, 16)) - 8;
            coord_y = int'($urandom_range(0, 16)) - 8;
         end else begin
            coord_x = $urandom;
            coord_y = $urandom;
         end
         case ($urandom_range(0, 7))
            0: demand = $urandom;
            1: demand = 0;
            default: demand = (fleet_capacity == 0) ? int'($urandom_range(0, 1))
                                                    : $urandom_range(0, fleet_capacity / 3 + 1);
         endcase
         push_node(coord_x, coord_y, demand, last);
      end
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         offer = req_valid;
         if (req_valid && req_ready) begin
            evaluate_node(node_on_bus);
            items_outstanding--;
            send_gap = draw_gap();
            offer = 1'b0;
         end
         if (!offer) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (node_q.size() > 0) begin
               node_on_bus = node_q.pop_front();
               req_node_x      <= node_on_bus.x;
               req_node_y      <= node_on_bus.y;
               req_node_demand <= node_on_bus.demand;
               req_last_node   <= node_on_bus.last;
               offer = 1'b1;
            end
         end
         req_valid <= offer;
      end
   end

   // monitor and receiver
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left = draw_gap();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (route_totals_q.size() == 0) begin
               report_mismatch($sformatf("unexpected result visits=%0d distance=%0h",
                                         rsp_depot_visits, rsp_route_distance));
            end else begin
               route_total_type want;
               want = route_totals_q.pop_front();
               if (rsp_depot_visits !== want.visits)
                  report_mismatch($sformatf("depot_visits got %0d want %0d",
                                            rsp_depot_visits, want.visits));
               if (rsp_route_distance !== want.distance)
                  report_mismatch($sformatf("route_distance got %0h want %0h",
                                            rsp_route_distance, want.distance));
            end
            stall_left = draw_gap();
         end
         if (long_holds_done < long_holds_asked) begin
            stall_left   = LONG_HOLD;
            long_hold_on = 1'b1;
            long_holds_done++;
         end
         if (stall_left == 0)
            long_hold_on = 1'b0;
         rsp_ready <= (stall_left == 0);
         if (stall_left > 0 && (rsp_valid || long_hold_on))
            stall_left--;
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      logic [crse_pkg::CAP_W-1:0] phase_caps[6];
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // tour at the reset capacity of zero
      push_node(3, 4, 0, 1'b1);
      wait_idle();

      write_capacity(16'd100);
      push_node(0, 0, 0, 1'b1);
      push_node(32767, 32767, 40, 1'b0);
      push_node(-32768, -32768, 40, 1'b0);
      push_node(-32768, 32767, 30, 1'b0);
      push_node(32767, -32768, 0, 1'b1);
      // refill on first node, then negative load forcing refills
      push_node(100, -200, 150, 1'b0);
      push_node(-5, 7, 0, 1'b0);
      push_node(1, 1, 65535, 1'b1);
      push_node(-1, -1, 65535, 1'b0);
      push_node(0, 0, 100, 1'b0);
      push_node(2, -3, 0, 1'b0);
      push_node(7, 7, 1, 1'b0);
      wait_idle();

      // capacity change while a tour is open
      write_capacity(16'hFFFF);
      push_node(9, -9, 65535, 1'b0);
      push_node(10, 10, 0, 1'b1);
      push_node(-32768, -32768, 65535, 1'b0);
      push_node(32767, 32767, 65535, 1'b1);
      wait_idle();

      write_capacity(16'd0);
      push_node(5, 5, 0, 1'b0);
      push_node(6, 6, 1, 1'b1);
      wait_idle();

      // long tour, refilling at every node
      for (int i = 0; i < OVERLONG_NODES; i++)
         push_node(int'($urandom_range(0, 20)) - 10, int'($urandom_range(0, 20)) - 10, 1,
                   i == OVERLONG_NODES - 1);
      wait_idle();

      phase_caps[0] = 16'hFFFF;
      phase_caps[1] = 16'd0;
      phase_caps[2] = 16'($urandom_range(1, 300));
      phase_caps[3] = 16'($urandom);
      phase_caps[4] = 16'd1000;
      phase_caps[5] = 16'($urandom_range(50, 5000));
      for (int p = 0; p < 6; p++) begin
         write_capacity(phase_caps[p]);
         quiet_mode = (p == 3);
         queue_random_tours(110, p % 2 == 0);
         wait_idle();
      end

      // hold off the result side so the block backs up into its input
      write_capacity(16'($urandom_range(1, 500)));
      quiet_mode = 1'b1;
      long_holds_asked++;
      for (int i = 0; i < 12; i++)
         push_node($urandom, $urandom, $urandom_range(0, 600), 1'b1);
      wait_idle();

      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/crse_pkg.sv
rtl/capacity_route_split_evaluator_unit.sv
dv/tb_top.sv
